### sv/lcag_pkg.sv
`default_nettype none

package lcag_pkg;

   localparam int unsigned MAX_ROWS_DEFAULT    = 64;
   localparam int unsigned MAX_COLUMNS_DEFAULT = 64;

   // configuration registers
   localparam int unsigned CFG_WIDTH = 7;
   localparam logic [CFG_WIDTH-1:0] ROW_COUNT_RESET    = 7'd20;
   localparam logic [CFG_WIDTH-1:0] COLUMN_COUNT_RESET = 7'd20;

   typedef enum logic {
      CSR_ROW_COUNT    = 1'b0,
      CSR_COLUMN_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_TOGGLE  = 2'd1,
      OP_READ    = 2'd2,
      OP_ADVANCE = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type opcode;
      logic [5:0] cell_row;
      logic [5:0] cell_column;
      logic       alive_value;
   } req_type;

   typedef struct packed {
      logic        cell_alive;
      logic [15:0] generation;
      logic        bad_address;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CELL,
      ST_FILL,
      ST_RUN,
      ST_HOLD
   } state_type;

endpackage

`default_nettype wire

### sv/lcag_ram.sv
`default_nettype none

module lcag_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### sv/lcag_next_row.sv
`default_nettype none

module lcag_next_row #(
   parameter int unsigned COLUMNS = 64
) (
   input  wire logic [COLUMNS-1:0] above,
   input  wire logic [COLUMNS-1:0] here,
   input  wire logic [COLUMNS-1:0] below,
   input  wire logic [COLUMNS-1:0] mask,
   output logic      [COLUMNS-1:0] fresh
);

   // dead border on both sides, inputs are already masked to the grid width
   logic [COLUMNS+1:0] above_pad;
   logic [COLUMNS+1:0] here_pad;
   logic [COLUMNS+1:0] below_pad;

   assign above_pad = {1'b0, above, 1'b0};
   assign here_pad  = {1'b0, here, 1'b0};
   assign below_pad = {1'b0, below, 1'b0};

   always_comb begin
      logic [3:0] n;
      fresh = '0;
      for (int c = 0; c < COLUMNS; c++) begin
         n = {3'b0, above_pad[c]} + {3'b0, above_pad[c+1]} + {3'b0, above_pad[c+2]}
           + {3'b0, here_pad[c]}  + {3'b0, here_pad[c+2]}
           + {3'b0, below_pad[c]} + {3'b0, below_pad[c+1]} + {3'b0, below_pad[c+2]};
         fresh[c] = mask[c] && ((n == 4'd3) || ((n == 4'd2) && here[c]));
      end
   end

endmodule

`default_nettype wire

### sv/life_cellular_automaton_grid_core.sv
// Game of life grid (B3/S23, non-wrapping) held in a row-wide RAM.
// req channel: one operation per transfer (write, toggle, read cell, or
// advance one generation). rsp channel: exactly one result per request,
// in request order: cell state, generation count, bad address flag.
// csr port: csr_we/csr_addr/csr_wdata set row_count and column_count;
// write only while no request is in flight.
// Sequence per operation:
//   write/toggle/read: RAM read of the row, then write back in ST_CELL,
//   where the result is registered; req stalls until the block is idle again
//   bad address, or advance on an empty grid: result registered straight from idle
//   advance: ST_FILL, then ST_RUN, one row streamed through the RAM read port
//   and the rule logic per cycle, writing back one row behind the reads
// Reset: synchronous; all cells read dead, generation is zero, both
// counts are 20. Per-row valid bits make unwritten rows read as dead, so
// there is no clearing pass and the block is ready right after reset.
// Stall: the result sits in an output register; a new request is still
// taken while it waits, and the block then holds its own finished result
// and stalls req until the output register drains.
`default_nettype none

module life_cellular_automaton_grid_core #(
   parameter int unsigned MAX_ROWS    = lcag_pkg::MAX_ROWS_DEFAULT,
   parameter int unsigned MAX_COLUMNS = lcag_pkg::MAX_COLUMNS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire lcag_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output lcag_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_we,
   input  wire logic                               csr_addr,
   input  wire logic [lcag_pkg::CFG_WIDTH-1:0]     csr_wdata
);

   localparam int unsigned RAW = $clog2(MAX_ROWS);
   localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
   localparam int unsigned CAW = $clog2(MAX_COLUMNS);
   localparam int unsigned CCW = $clog2(MAX_COLUMNS + 1);
   localparam int unsigned RW  = (RCW > lcag_pkg::CFG_WIDTH) ? RCW : lcag_pkg::CFG_WIDTH;
   localparam int unsigned CW  = (CCW > lcag_pkg::CFG_WIDTH) ? CCW : lcag_pkg::CFG_WIDTH;

   lcag_pkg::state_type state_ff, state_in;

   logic [lcag_pkg::CFG_WIDTH-1:0] rows_ff;
   logic [lcag_pkg::CFG_WIDTH-1:0] cols_ff;
   logic [15:0]                    gen_ff, gen_in;

   lcag_pkg::opcode_type op_ff;
   logic [RAW-1:0]       row_ff;
   logic [CAW-1:0]       col_ff;
   logic                 val_ff;

   logic [RCW-1:0]         rd_next_ff, rd_next_in;
   logic [RCW-1:0]         wr_ff, wr_in;
   logic [MAX_COLUMNS-1:0] above_ff, above_in;
   logic [MAX_COLUMNS-1:0] here_ff, here_in;
   logic [MAX_COLUMNS-1:0] here_raw_ff, here_raw_in;
   logic                   rd_valid_ff;
   logic [MAX_ROWS-1:0]    row_valid_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   lcag_pkg::rsp_type rsp_data_ff, rsp_data_in;
   lcag_pkg::rsp_type pend_ff;

   logic [RCW-1:0]         rows_eff;
   logic [CCW-1:0]         cols_eff;
   logic [MAX_COLUMNS-1:0] col_mask;
   logic                   req_fire;
   logic                   out_free;
   logic                   addr_bad;
   logic                   below_ok;
   logic                   run_last;
   logic                   rd_more;
   logic [MAX_COLUMNS-1:0] rd_row;
   logic [MAX_COLUMNS-1:0] below_row;
   logic [MAX_COLUMNS-1:0] fresh;
   logic                   cell_old;
   logic                   cell_new;
   logic [MAX_COLUMNS-1:0] cell_wdata;

   logic                   ram_we;
   logic [RAW-1:0]         ram_waddr;
   logic [MAX_COLUMNS-1:0] ram_wdata;
   logic [RAW-1:0]         ram_raddr;
   logic [MAX_COLUMNS-1:0] ram_rdata;

   logic              done;
   logic              gen_inc;
   lcag_pkg::rsp_type done_data;

   // effective grid size, saturated at the array size
   assign rows_eff = (RW'(rows_ff) > RW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(rows_ff);
   assign cols_eff = (CW'(cols_ff) > CW'(MAX_COLUMNS)) ? CCW'(MAX_COLUMNS) : CCW'(cols_ff);

   always_comb begin
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         col_mask[c] = (CCW'(c) < cols_eff);
      end
   end

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != lcag_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign addr_bad  = (RW'(req_data.cell_row) >= RW'(rows_eff))
                   || (CW'(req_data.cell_column) >= CW'(cols_eff));

   // rows never written read as dead
   assign rd_row    = ram_rdata & {MAX_COLUMNS{rd_valid_ff}};
   assign below_ok  = (RCW'(wr_ff + RCW'(1)) < rows_eff);
   assign below_row = below_ok ? (rd_row & col_mask) : '0;
   assign run_last  = (wr_ff == RCW'(rows_eff - RCW'(1)));
   assign rd_more   = (rd_next_ff < rows_eff);

   assign cell_old = rd_row[col_ff];

   always_comb begin
      unique case (op_ff)
         lcag_pkg::OP_WRITE:  cell_new = val_ff;
         lcag_pkg::OP_TOGGLE: cell_new = !cell_old;
         default:             cell_new = cell_old;
      endcase
      cell_wdata         = rd_row;
      cell_wdata[col_ff] = cell_new;
   end

   lcag_next_row #(
      .COLUMNS (MAX_COLUMNS)
   ) u_next_row (
      .above (above_ff),
      .here  (here_ff),
      .below (below_row),
      .mask  (col_mask),
      .fresh (fresh)
   );

   lcag_ram #(
      .WIDTH (MAX_COLUMNS),
      .DEPTH (MAX_ROWS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcag_pkg::ST_IDLE: begin
            if (req_fire) begin
               if ((req_data.opcode == lcag_pkg::OP_ADVANCE) && (rows_eff != '0)) begin
                  state_in = lcag_pkg::ST_FILL;
               end else if ((req_data.opcode != lcag_pkg::OP_ADVANCE) && !addr_bad) begin
                  state_in = lcag_pkg::ST_CELL;
               end else if (!out_free) begin
                  state_in = lcag_pkg::ST_HOLD;
               end
            end
         end
         lcag_pkg::ST_CELL: begin
            state_in = out_free ? lcag_pkg::ST_IDLE : lcag_pkg::ST_HOLD;
         end
         lcag_pkg::ST_FILL: begin
            state_in = lcag_pkg::ST_RUN;
         end
         lcag_pkg::ST_RUN: begin
            if (run_last) begin
               state_in = out_free ? lcag_pkg::ST_IDLE : lcag_pkg::ST_HOLD;
            end
         end
         lcag_pkg::ST_HOLD: begin
            if (out_free) begin
               state_in = lcag_pkg::ST_IDLE;
            end
         end
         default: state_in = lcag_pkg::ST_IDLE;
      endcase
   end

   // an accepted advance counts the generation at once
   assign gen_inc = req_fire && (req_data.opcode == lcag_pkg::OP_ADVANCE);

   // outputs of the sequencer: RAM ports and completion
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = row_ff;
      ram_wdata = cell_wdata;
      ram_raddr = rd_next_ff[RAW-1:0];
      done      = 1'b0;
      done_data = '{cell_alive: 1'b0, generation: gen_in, bad_address: 1'b0};
      unique case (state_ff)
         lcag_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_data.opcode == lcag_pkg::OP_ADVANCE) begin
                  ram_raddr = '0;
                  done      = (rows_eff == '0);
               end else if (addr_bad) begin
                  done                  = 1'b1;
                  done_data.bad_address = 1'b1;
               end else begin
                  ram_raddr = RAW'(req_data.cell_row);
               end
            end
         end
         lcag_pkg::ST_CELL: begin
            done                 = 1'b1;
            done_data.cell_alive = cell_new;
            ram_we = (op_ff == lcag_pkg::OP_WRITE) || (op_ff == lcag_pkg::OP_TOGGLE);
         end
         lcag_pkg::ST_FILL: begin
         end
         lcag_pkg::ST_RUN: begin
            // cells beyond the configured width keep their old contents
            ram_we    = 1'b1;
            ram_waddr = wr_ff[RAW-1:0];
            ram_wdata = (here_raw_ff & ~col_mask) | fresh;
            done      = run_last;
         end
         lcag_pkg::ST_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   assign gen_in = gen_inc ? (gen_ff + 16'd1) : gen_ff;

   // row window for the advance sweep
   always_comb begin
      rd_next_in  = rd_next_ff;
      wr_in       = wr_ff;
      above_in    = above_ff;
      here_in     = here_ff;
      here_raw_in = here_raw_ff;
      unique case (state_ff)
         lcag_pkg::ST_IDLE: begin
            rd_next_in = RCW'(1);
            wr_in      = '0;
            above_in   = '0;
         end
         lcag_pkg::ST_FILL: begin
            here_in     = rd_row & col_mask;
            here_raw_in = rd_row;
            if (rd_more) begin
               rd_next_in = RCW'(rd_next_ff + RCW'(1));
            end
         end
         lcag_pkg::ST_RUN: begin
            above_in    = here_ff;
            here_in     = below_row;
            here_raw_in = rd_row;
            wr_in       = RCW'(wr_ff + RCW'(1));
            if (rd_more) begin
               rd_next_in = RCW'(rd_next_ff + RCW'(1));
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == lcag_pkg::ST_HOLD) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pend_ff;
      end else if (done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcag_pkg::ST_IDLE;
         rows_ff      <= lcag_pkg::ROW_COUNT_RESET;
         cols_ff      <= lcag_pkg::COLUMN_COUNT_RESET;
         gen_ff       <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_we) begin
            row_valid_ff[ram_waddr] <= 1'b1;
         end
         if (csr_we) begin
            if (csr_addr == lcag_pkg::CSR_ROW_COUNT) begin
               rows_ff <= csr_wdata;
            end else begin
               cols_ff <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_data.opcode;
         row_ff <= RAW'(req_data.cell_row);
         col_ff <= CAW'(req_data.cell_column);
         val_ff <= req_data.alive_value;
      end
      if (done) begin
         pend_ff <= done_data;
      end
      rd_next_ff  <= rd_next_in;
      wr_ff       <= wr_in;
      above_ff    <= above_in;
      here_ff     <= here_in;
      here_raw_ff <= here_raw_in;
      rd_valid_ff <= row_valid_ff[ram_raddr];
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### sv/lcag_checker.sv
`default_nettype none

module lcag_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire lcag_pkg::rsp_type rsp_data
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [2:0] open_ff, open_in;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // requests taken but not yet answered
   always_comb begin
      open_in = open_ff;
      if (req_xfer && !rsp_xfer) begin
         open_in = 3'(open_ff + 3'd1);
      end else if (rsp_xfer && !req_xfer) begin
         open_in = 3'(open_ff - 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 3'd0)
      else $error("result without an open request");

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff <= 3'd2)
      else $error("more than two requests in flight");

   a_bad_dead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_address |-> !rsp_data.cell_alive)
      else $error("bad address result reports a live cell");

endmodule

bind life_cellular_automaton_grid_core lcag_checker u_checker (.*);

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned GRID_ROWS    = lcag_pkg::MAX_ROWS_DEFAULT;
   localparam int unsigned GRID_COLUMNS = lcag_pkg::MAX_COLUMNS_DEFAULT;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES    = GRID_ROWS + 16;

   typedef struct {
      lcag_pkg::req_type request;
      bit                typed;
      lcag_pkg::rsp_type answer;
   } script_line_type;

   typedef struct {
      logic [lcag_pkg::CFG_WIDTH-1:0] rows;
      logic [lcag_pkg::CFG_WIDTH-1:0] columns;
      int unsigned                    items;
   } grid_phase_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   lcag_pkg::req_type              req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   lcag_pkg::rsp_type              rsp_data;
   logic                           csr_we = 1'b0;
   lcag_pkg::csr_index_type        csr_addr = lcag_pkg::CSR_ROW_COUNT;
   logic [lcag_pkg::CFG_WIDTH-1:0] csr_wdata = '0;

   // predictor state
   bit [GRID_COLUMNS-1:0]          grid_rows [GRID_ROWS];
   logic [15:0]                    generation_now;
   logic [lcag_pkg::CFG_WIDTH-1:0] row_count_now;
   logic [lcag_pkg::CFG_WIDTH-1:0] column_count_now;

   lcag_pkg::rsp_type pending_results [$];
   int                error_count = 0;
   bit                quiet_ending = 1'b0;
   bit                hold_off_request = 1'b0;

   // directed part at the reset size of 20 x 20
   script_line_type script [24] = '{
      '{'{lcag_pkg::OP_READ,    6'd0,  6'd0,  1'b0}, 1'b1, '{1'b0, 16'd0, 1'b0}},
      '{'{lcag_pkg::OP_WRITE,   6'd19, 6'd19, 1'b1}, 1'b1, '{1'b1, 16'd0, 1'b0}},
      '{'{lcag_pkg::OP_WRITE,   6'd63, 6'd63, 1'b1}, 1'b1, '{1'b0, 16'd0, 1'b1}},
      '{'{lcag_pkg::OP_TOGGLE,  6'd20, 6'd0,  1'b0}, 1'b1, '{1'b0, 16'd0, 1'b1}},
      '{'{lcag_pkg::OP_READ,    6'd0,  6'd20, 1'b1}, 1'b1, '{1'b0, 16'd0, 1'b1}},
      '{'{lcag_pkg::OP_WRITE,   6'd0,  6'd0,  1'b1}, 1'b1, '{1'b1, 16'd0, 1'b0}},
      '{'{lcag_pkg::OP_WRITE,   6'd0,  6'd1,  1'b1}, 1'b1, '{1'b1, 16'd0, 1'b0}},
      '{'{lcag_pkg::OP_WRITE,   6'd0,  6'd2,  1'b1}, 1'b1, '{1'b1, 16'd0, 1'b0}},
      '{'{lcag_pkg::OP_TOGGLE,  6'd19, 6'd19, 1'b0}, 1'b1, '{1'b0, 16'd0, 1'b0}},
      '{'{lcag_pkg::OP_TOGGLE,  6'd19, 6'd19, 1'b1}, 1'b1, '{1'b1, 16'd0, 1'b0}},
      '{'{lcag_pkg::OP_WRITE,   6'd19, 6'd19, 1'b0}, 1'b1, '{1'b0, 16'd0, 1'b0}},
      '{'{lcag_pkg::OP_ADVANCE, 6'd63, 6'd63, 1'b1}, 1'b1, '{1'b0, 16'd1, 1'b0}},
      '{'{lcag_pkg::OP_READ,    6'd1,  6'd1,  1'b0}, 1'b0, '0},
      '{'{lcag_pkg::OP_READ,    6'd0,  6'd1,  1'b0}, 1'b0, '0},
      '{'{lcag_pkg::OP_READ,    6'd0,  6'd0,  1'b0}, 1'b0, '0},
      '{'{lcag_pkg::OP_WRITE,   6'd18, 6'd18, 1'b1}, 1'b1, '{1'b1, 16'd1, 1'b0}},
      '{'{lcag_pkg::OP_WRITE,   6'd18, 6'd19, 1'b1}, 1'b1, '{1'b1, 16'd1, 1'b0}},
      '{'{lcag_pkg::OP_WRITE,   6'd19, 6'd18, 1'b1}, 1'b1, '{1'b1, 16'd1, 1'b0}},
      '{'{lcag_pkg::OP_WRITE,   6'd19, 6'd19, 1'b1}, 1'b1, '{1'b1, 16'd1, 1'b0}},
      '{'{lcag_pkg::OP_ADVANCE, 6'd0,  6'd0,  1'b0}, 1'b1, '{1'b0, 16'd2, 1'b0}},
      '{'{lcag_pkg::OP_READ,    6'd19, 6'd19, 1'b0}, 1'b0, '0},
      '{'{lcag_pkg::OP_READ,    6'd1,  6'd1,  1'b1}, 1'b0, '0},
      '{'{lcag_pkg::OP_WRITE,   6'd5,  6'd5,  1'b0}, 1'b1, '{1'b0, 16'd2, 1'b0}},
      '{'{lcag_pkg::OP_TOGGLE,  6'd31, 6'd45, 1'b1}, 1'b1, '{1'b0, 16'd2, 1'b1}}
   };

   grid_phase_type phases [13] = '{
      '{7'd20,  7'd20,  60},
      '{7'd1,   7'd1,   20},
      '{7'd0,   7'd0,   12},
      '{7'd0,   7'd9,   10},
      '{7'd9,   7'd0,   10},
      '{7'd3,   7'd7,   60},
      '{7'd64,  7'd64,  100},
      '{7'd127, 7'd127, 40},
      '{7'd5,   7'd64,  50},
      '{7'd64,  7'd3,   40},
      '{7'd12,  7'd100, 50},
      '{7'd1,   7'd64,  20},
      '{7'd8,   7'd8,   60}
   };

   life_cellular_automaton_grid_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int unsigned clamp_size(logic [lcag_pkg::CFG_WIDTH-1:0] value,
                                              int unsigned limit);
      return (value > limit) ? limit : int'(value);
   endfunction

   // one B3/S23 generation over the configured window, row above kept as it was
   function automatic void evolve_grid();
      int unsigned           nrows;
      int unsigned           ncols;
      int unsigned           count;
      bit [GRID_COLUMNS-1:0] mask;
      bit [GRID_COLUMNS-1:0] upper;
      bit [GRID_COLUMNS-1:0] here;
      bit [GRID_COLUMNS-1:0] lower;
      bit [GRID_COLUMNS-1:0] fresh;
      nrows = clamp_size(row_count_now, GRID_ROWS);
      ncols = clamp_size(column_count_now, GRID_COLUMNS);
      mask  = '0;
      for (int c = 0; c < ncols; c++) mask[c] = 1'b1;
      upper = '0;
      for (int r = 0; r < nrows; r++) begin
         here  = grid_rows[r] & mask;
         lower = (r + 1 < nrows) ? (grid_rows[r + 1] & mask) : '0;
         fresh = '0;
         for (int c = 0; c < ncols; c++) begin
            count = upper[c] + lower[c];
            if (c > 0) count = count + upper[c - 1] + here[c - 1] + lower[c - 1];
            if (c + 1 < ncols) count = count + upper[c + 1] + here[c + 1] + lower[c + 1];
            fresh[c] = (count == 3) || (count == 2 && here[c]);
         end
         grid_rows[r] = (grid_rows[r] & ~mask) | fresh;
         upper = here;
      end
      generation_now = generation_now + 16'd1;
   endfunction

   function automatic lcag_pkg::rsp_type apply_grid_op(lcag_pkg::req_type item);
      lcag_pkg::rsp_type result;
      result = '0;
      if (item.opcode == lcag_pkg::OP_ADVANCE) begin
         evolve_grid();
      end else if (item.cell_row >= clamp_size(row_count_now, GRID_ROWS) ||
                   item.cell_column >= clamp_size(column_count_now, GRID_COLUMNS)) begin
         result.bad_address = 1'b1;
      end else begin
         unique case (item.opcode)
            lcag_pkg::OP_WRITE:  grid_rows[item.cell_row][item.cell_column] = item.alive_value;
            lcag_pkg::OP_TOGGLE: grid_rows[item.cell_row][item.cell_column] =
                                    ~grid_rows[item.cell_row][item.cell_column];
            default: ;
         endcase
         result.cell_alive = grid_rows[item.cell_row][item.cell_column];
      end
      result.generation = generation_now;
      return result;
   endfunction

   // mostly in-range cell work with some advances, the rest anywhere in the field range
   function automatic lcag_pkg::req_type random_request();
      lcag_pkg::req_type item;
      int unsigned       nrows;
      int unsigned       ncols;
      int unsigned       pick;
      nrows = clamp_size(row_count_now, GRID_ROWS);
      ncols = clamp_size(column_count_now, GRID_COLUMNS);
      pick  = $urandom_range(0, 99);
      item.alive_value = 1'($urandom_range(0, 1));
      if (pick < 10)
         item.opcode = lcag_pkg::OP_ADVANCE;
      else
         item.opcode = lcag_pkg::opcode_type'($urandom_range(0, 2));
      if (pick >= 90 || item.opcode == lcag_pkg::OP_ADVANCE || nrows == 0 || ncols == 0) begin
         item.cell_row    = 6'($urandom_range(0, 63));
         item.cell_column = 6'($urandom_range(0, 63));
      end else begin
         item.cell_row    = 6'($urandom_range(0, nrows - 1));
         item.cell_column = 6'($urandom_range(0, ncols - 1));
      end
      return item;
   endfunction

   task automatic offer_request(input lcag_pkg::req_type item, input bit typed,
                                input lcag_pkg::rsp_type answer);
      lcag_pkg::rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= item;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      predicted = apply_grid_op(item);
      if (typed) predicted = answer;
      pending_results = {pending_results, predicted};
      if (!quiet_ending && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_grid_size(input logic [lcag_pkg::CFG_WIDTH-1:0] rows,
                                input logic [lcag_pkg::CFG_WIDTH-1:0] columns);
      csr_we    <= 1'b1;
      csr_addr  <= lcag_pkg::CSR_ROW_COUNT;
      csr_wdata <= rows;
      @(posedge clock);
      csr_addr  <= lcag_pkg::CSR_COLUMN_COUNT;
      csr_wdata <= columns;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      row_count_now    = rows;
      column_count_now = columns;
   endtask

   function automatic void check_field(string label, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         error_count++;
      end
   endfunction

   // result transfer happens at the next rising edge; inputs are stable here
   always @(negedge clock) begin
      lcag_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("cell_alive", 16'(want.cell_alive), 16'(rsp_data.cell_alive));
            check_field("generation", want.generation, rsp_data.generation);
            check_field("bad_address", 16'(want.bad_address), 16'(rsp_data.bad_address));
         end
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (!quiet_ending && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      foreach (grid_rows[r]) grid_rows[r] = '0;
      generation_now   = '0;
      row_count_now    = lcag_pkg::ROW_COUNT_RESET;
      column_count_now = lcag_pkg::COLUMN_COUNT_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) offer_request(script[i].request, script[i].typed, script[i].answer);

      foreach (phases[p]) begin
         drain_results();
         set_grid_size(phases[p].rows, phases[p].columns);
         if (p == $size(phases) - 1) quiet_ending = 1'b1;
         // full grid: let the output side back up so the block stalls its input
         if (phases[p].rows == 7'd64 && phases[p].columns == 7'd64) hold_off_request = 1'b1;
         repeat (phases[p].items) offer_request(random_request(), 1'b0, '0);
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
